// ----- src/dlmeb_pkg.sv -----
// package for the list-mode event builder: field widths, codes, control types
// no dependencies
package dlmeb_pkg;

    localparam int DEF_CHANNELS_PER_BOARD = 16;
    localparam int DEF_BOARDS_PER_CRATE   = 13;
    localparam int DEF_MAX_MULTIPLICITY   = 256;

    localparam int TS_W    = 48;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 14;
    localparam int MULT_W  = 9;
    localparam int ID_W    = 13;
    localparam int EN_W    = 16;
    localparam int ODATA_W = 168;

    localparam logic [47:0] RST_EVENT_WINDOW = 48'd100;
    localparam logic [15:0] RST_ENERGY_DIV   = 16'd1;
    localparam logic [3:0]  RST_FIRST_SLOT   = 4'd2;

    typedef enum logic [1:0] {
        CFG_EVENT_WINDOW = 2'd0,
        CFG_ENERGY_DIV   = 2'd1,
        CFG_FIRST_SLOT   = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_TRACE  = 2'd1,
        KIND_CLOSE  = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DIV   = 2'd1,
        ST_CLOSE = 2'd2,
        ST_HDR   = 2'd3
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_div;
        logic load_close;
        logic load_hdr;
    } t_ctl_cmd;

    typedef struct packed {
        logic hdr_word;
        logic close_pend;
        logic div_busy;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- src/dlmeb_div.sv -----
// iterative 16-bit unsigned divider, one quotient bit per cycle
// depends on dlmeb_pkg
module dlmeb_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [dlmeb_pkg::EN_W-1:0] i_dividend,
    input  logic [dlmeb_pkg::EN_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [dlmeb_pkg::EN_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(dlmeb_pkg::EN_W + 1);

    logic [dlmeb_pkg::EN_W-1:0] r_rem, r_quo, r_dvs;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic [dlmeb_pkg::EN_W:0]   rem_sh, diff;

    assign rem_sh = {r_rem, r_quo[dlmeb_pkg::EN_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(dlmeb_pkg::EN_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= (i_divisor == '0) ? dlmeb_pkg::EN_W'(1) : i_divisor;
        end else if (r_busy) begin
            if (!diff[dlmeb_pkg::EN_W]) begin
                r_rem <= diff[dlmeb_pkg::EN_W-1:0];
                r_quo <= {r_quo[dlmeb_pkg::EN_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[dlmeb_pkg::EN_W-1:0];
                r_quo <= {r_quo[dlmeb_pkg::EN_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

// ----- src/dlmeb_dp.sv -----
// datapath: config registers, header decode, event window logic, output register
// depends on dlmeb_pkg and dlmeb_div
module dlmeb_dp #(
    parameter int CHANNELS_PER_BOARD = dlmeb_pkg::DEF_CHANNELS_PER_BOARD,
    parameter int BOARDS_PER_CRATE   = dlmeb_pkg::DEF_BOARDS_PER_CRATE,
    parameter int MAX_MULTIPLICITY   = dlmeb_pkg::DEF_MAX_MULTIPLICITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlmeb_pkg::t_ctl_cmd           i_cmd,
    output dlmeb_pkg::t_dp_sts            o_sts,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [47:0]                   i_cfg_data,
    input  logic                          i_action,
    input  logic [dlmeb_pkg::WORD_W-1:0]  i_word,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_out_kind,
    output logic [dlmeb_pkg::ODATA_W-1:0] o_out_data
);
    localparam int MULT_CAP = (MAX_MULTIPLICITY > 511) ? 511 : MAX_MULTIPLICITY;
    localparam logic [12:0] CRATE_MUL = 13'(BOARDS_PER_CRATE * CHANNELS_PER_BOARD);
    localparam logic [12:0] SLOT_MUL  = 13'(CHANNELS_PER_BOARD);

    logic [47:0] r_window;
    logic [15:0] r_divisor;
    logic [3:0]  r_first_slot;

    logic [dlmeb_pkg::POS_W-1:0]  r_pos, r_se_words;
    logic [31:0]                  r_w0, r_tlo, r_thi, r_w3;
    logic [47:0]                  r_ref, r_ts;
    logic                         r_ref_valid, r_err, r_close_pend;
    logic [dlmeb_pkg::MULT_W-1:0] r_count, r_close_mult;
    logic [1:0]                   r_hdr_kind;

    logic                         r_out_valid;
    logic [1:0]                   r_out_kind;
    logic [dlmeb_pkg::ODATA_W-1:0] r_out_data;

    logic [47:0] ts_now, ts_diff;
    logic [4:0]  hlen;
    logic [4:0]  tstart;
    logic [13:0] elen_now;
    logic [14:0] trlen_now;
    logic [13:0] se_now;
    logic [dlmeb_pkg::MULT_W-1:0] count_inc;
    logic        div_busy;
    logic [15:0] quotient;
    logic [12:0] det_id;
    logic        out_free;

    assign out_free  = !r_out_valid || i_out_ready;
    assign hlen      = r_w0[16:12];
    assign tstart    = (hlen > 5'd4) ? hlen : 5'd4;
    assign ts_now    = {r_thi[15:0], r_tlo};
    assign ts_diff   = ts_now - r_ref;
    assign elen_now  = r_w0[30:17];
    assign trlen_now = i_word[30:16];
    assign se_now    = (hlen == 5'd4 && trlen_now[14:1] == '0) ? 14'd4 : elen_now;
    assign count_inc = (r_count < dlmeb_pkg::MULT_W'(MULT_CAP)) ? r_count + 1'b1 : r_count;
    assign det_id    = 13'(r_w0[11:8]) * CRATE_MUL
                     + (13'(r_w0[7:4]) - 13'(r_first_slot)) * SLOT_MUL + 13'(r_w0[3:0]);

    dlmeb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (i_word[15:0]),
        .i_divisor  (r_divisor),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= dlmeb_pkg::RST_EVENT_WINDOW;
            r_divisor    <= dlmeb_pkg::RST_ENERGY_DIV;
            r_first_slot <= dlmeb_pkg::RST_FIRST_SLOT;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                dlmeb_pkg::CFG_EVENT_WINDOW: r_window     <= i_cfg_data;
                dlmeb_pkg::CFG_ENERGY_DIV:   r_divisor    <= i_cfg_data[15:0];
                dlmeb_pkg::CFG_FIRST_SLOT:   r_first_slot <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_se_words   <= '0;
            r_w0         <= '0;
            r_tlo        <= '0;
            r_thi        <= '0;
            r_ref        <= '0;
            r_ref_valid  <= 1'b0;
            r_count      <= '0;
            r_err        <= 1'b0;
            r_close_pend <= 1'b0;
            r_hdr_kind   <= dlmeb_pkg::KIND_HEADER;
        end else if (i_cmd.accept && !r_err) begin
            if (i_action) begin
                r_pos <= '0;
                if (r_ref_valid) begin
                    r_ref_valid <= 1'b0;
                    r_count     <= '0;
                end
            end else begin
                case (r_pos)
                    14'd0: begin
                        r_w0  <= i_word;
                        r_pos <= 14'd1;
                    end
                    14'd1: begin
                        r_tlo <= i_word;
                        r_pos <= 14'd2;
                    end
                    14'd2: begin
                        r_thi <= i_word;
                        r_pos <= 14'd3;
                    end
                    14'd3: begin
                        r_close_pend <= 1'b0;
                        r_hdr_kind   <= dlmeb_pkg::KIND_HEADER;
                        if (r_ref_valid && ts_now < r_ref) begin
                            r_err      <= 1'b1;
                            r_hdr_kind <= dlmeb_pkg::KIND_ERROR;
                            r_pos      <= '0;
                        end else begin
                            if (!r_ref_valid) begin
                                r_ref_valid <= 1'b1;
                                r_ref       <= ts_now;
                                r_count     <= dlmeb_pkg::MULT_W'(1);
                            end else if (ts_diff > r_window) begin
                                r_close_pend <= 1'b1;
                                r_ref        <= ts_now;
                                r_count      <= dlmeb_pkg::MULT_W'(1);
                            end else begin
                                r_count <= count_inc;
                            end
                            r_se_words <= se_now;
                            r_pos      <= (se_now > 14'd4) ? 14'd4 : 14'd0;
                        end
                    end
                    default: begin
                        if (r_pos + 1'b1 >= r_se_words) begin
                            r_pos <= '0;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !r_err && !i_action && r_pos == 14'd3) begin
            r_ts         <= ts_now;
            r_w3         <= i_word;
            r_close_mult <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_close || i_cmd.load_hdr) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.accept && !r_err && i_action && r_ref_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.accept && !r_err && !i_action && r_pos > 14'd3
                     && r_pos >= 14'(tstart)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_close) begin
            r_out_kind <= dlmeb_pkg::KIND_CLOSE;
            r_out_data <= {4'd0, r_close_mult, 155'd0};
        end else if (i_cmd.load_hdr) begin
            r_out_kind <= r_hdr_kind;
            r_out_data <= {4'd0, 9'd0, 14'd0, 14'd0, r_w3[30:16], quotient,
                           r_thi[30:16], r_ts, r_w0[31], r_w0[30:17], r_w0[16:12], det_id};
        end else if (i_cmd.accept && i_action) begin
            r_out_kind <= dlmeb_pkg::KIND_CLOSE;
            r_out_data <= {4'd0, r_count, 155'd0};
        end else if (i_cmd.accept) begin
            r_out_kind <= dlmeb_pkg::KIND_TRACE;
            r_out_data <= {4'd0, 9'd0, i_word[29:16], i_word[13:0], 127'd0};
        end
    end

    assign o_sts.hdr_word   = !i_action && !r_err && r_pos == 14'd3;
    assign o_sts.close_pend = r_close_pend;
    assign o_sts.div_busy   = div_busy;
    assign o_sts.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_data  = r_out_data;
endmodule

// ----- src/dlmeb_ctrl.sv -----
// controller: sequences header decode, divide and up to two results per request
// depends on dlmeb_pkg
module dlmeb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dlmeb_pkg::t_dp_sts  i_sts,
    output dlmeb_pkg::t_ctl_cmd o_cmd
);
    dlmeb_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlmeb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dlmeb_pkg::ST_IDLE: begin
                o_in_ready   = i_sts.out_free;
                o_cmd.accept = i_in_valid && i_sts.out_free;
                if (o_cmd.accept && i_sts.hdr_word) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = dlmeb_pkg::ST_DIV;
                end
            end
            dlmeb_pkg::ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = i_sts.close_pend ? dlmeb_pkg::ST_CLOSE : dlmeb_pkg::ST_HDR;
                end
            end
            dlmeb_pkg::ST_CLOSE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_close = 1'b1;
                    n_state          = dlmeb_pkg::ST_HDR;
                end
            end
            dlmeb_pkg::ST_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_hdr = 1'b1;
                    n_state        = dlmeb_pkg::ST_IDLE;
                end
            end
            default: n_state = dlmeb_pkg::ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_close || o_cmd.load_hdr) |-> i_sts.out_free)
        else $error("result loaded while output slot full");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == dlmeb_pkg::ST_IDLE)
        else $error("request taken outside idle");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_div |=> (r_state == dlmeb_pkg::ST_DIV && i_sts.div_busy))
        else $error("divider not running after header");
    a_close_then_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_close |=> r_state == dlmeb_pkg::ST_HDR)
        else $error("close not followed by header");
`endif
endmodule

// ----- src/digitizer_list_mode_event_builder.sv -----
// top level of the list-mode event builder: controller plus datapath
// depends on dlmeb_pkg, dlmeb_ctrl, dlmeb_dp
//
// channel  | signals                         | payload
// s_axis   | tvalid tready tdata tuser       | tdata word[31:0], tuser action
// m_axis   | tvalid tready tdata tuser       | tdata result fields, tuser kind
// cfg      | i_cfg_valid o_cfg_ready addr    | i_cfg_data register value
//
// data, trace and sum words pass while the output register is free; a fourth header
// word starts the bit-serial 16-bit energy divider; input waits for its results
// a header that closes an event gives two results, close first
// reset is synchronous active low and clears all control state
// a stalled m_axis holds input back once the output register is full
module digitizer_list_mode_event_builder #(
    parameter int CHANNELS_PER_BOARD = dlmeb_pkg::DEF_CHANNELS_PER_BOARD,
    parameter int BOARDS_PER_CRATE   = dlmeb_pkg::DEF_BOARDS_PER_CRATE,
    parameter int MAX_MULTIPLICITY   = dlmeb_pkg::DEF_MAX_MULTIPLICITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // word[31:0]
    input  logic                          s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // detector_id[12:0] hdr_len[17:13] event_length[31:18] finish_code[32]
    // timestamp[80:33] cfd_time[95:81] energy[111:96] trace_length[126:112]
    // sample_first[140:127] sample_second[154:141] multiplicity[163:155] zero[167:164]
    output logic [dlmeb_pkg::ODATA_W-1:0] m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,  // kind
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [47:0]                   i_cfg_data
);
    dlmeb_pkg::t_ctl_cmd cmd;
    dlmeb_pkg::t_dp_sts  sts;

    assign o_cfg_ready = 1'b1;

    dlmeb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dlmeb_dp #(
        .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
        .BOARDS_PER_CRATE   (BOARDS_PER_CRATE),
        .MAX_MULTIPLICITY   (MAX_MULTIPLICITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_action    (s_axis_tuser),
        .i_word      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );
endmodule
